// ----- rtl/fpba_pkg.sv -----
// shared constants, codes and transfer types for the fit policy block allocator
// no dependencies
`default_nettype none

package fpba_pkg;

   localparam int NUM_BLOCKS = 8;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_POLICY    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCKS_IN_USE = 2'd1;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic [3:0] BLOCKS_IN_USE_RESET = 4'd8;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   typedef struct packed {
      logic        action;
      logic [2:0]  block_index;
      logic [15:0] size_value;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [2:0]  chosen_block;
      logic [15:0] remaining_size;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic update;
   } scan_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/fpba_table.sv -----
// free size table, one entry per block, cleared by reset
// depends on fpba_pkg
`default_nettype none

module fpba_table
   import fpba_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [IDX_BITS-1:0]  wr_addr,
   input  wire logic [SIZE_BITS-1:0] wr_data,
   input  wire logic [IDX_BITS-1:0]  rd_addr,
   output logic      [SIZE_BITS-1:0] rd_data
);

   logic [SIZE_BITS-1:0] entry_ff [NUM_BLOCKS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            entry_ff[k] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_addr];

endmodule

`default_nettype wire

// ----- rtl/fpba_scan_unit.sv -----
// shared subtract and compare unit that tracks the chosen block during a scan
// depends on fpba_pkg
`default_nettype none

module fpba_scan_unit
   import fpba_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire scan_ctl_type         ctl,
   input  wire logic [1:0]           policy,
   input  wire logic [SIZE_BITS-1:0] req_size,
   input  wire logic [SIZE_BITS-1:0] rd_data,
   input  wire logic [IDX_BITS-1:0]  rd_index,
   output logic                      found,
   output logic      [IDX_BITS-1:0]  pick,
   output logic      [SIZE_BITS-1:0] remainder
);

   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [SIZE_BITS-1:0] best_ff;
   logic [SIZE_BITS-1:0] oper_a;
   logic [SIZE_BITS:0]   diff;
   logic                 fits;
   logic                 better;
   logic                 take;

   assign oper_a = ctl.update ? best_ff : rd_data;
   assign diff   = {1'b0, oper_a} - {1'b0, req_size};
   assign fits   = ~diff[SIZE_BITS];

   always_comb begin
      case (policy)
         POL_BEST:  better = rd_data < best_ff;
         POL_WORST: better = rd_data > best_ff;
         default:   better = 1'b0;
      endcase
   end

   assign take = ctl.step && fits && (!found_ff || better);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pick_ff <= rd_index;
         best_ff <= rd_data;
      end
   end

   assign found     = found_ff;
   assign pick      = pick_ff;
   assign remainder = diff[SIZE_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/fit_policy_block_allocator.sv -----
// top level: sequencer, csr registers and result register of the block allocator
// depends on fpba_pkg, fpba_table and fpba_scan_unit
// load: result strobe in the cycle after the transfer, busy stays low
// allocate: scans S entries, then an update step, busy in both states, result strobe registered after the update,
//   S = min(blocks_in_use, NUM_BLOCKS); one table entry per cycle through one compare unit
// results are shown for one cycle only, the receiver cannot stall
// synchronous reset clears the table, sets first fit and blocks_in_use to 8
`default_nettype none

module fit_policy_block_allocator
   import fpba_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic [SIZE_BITS-1:0] req_size_ff, req_size_in;
   logic [1:0]           fit_policy_ff;
   logic [3:0]           blocks_in_use_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   scan_ctl_type         ctl;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] rd_data;
   logic                 found;
   logic [IDX_BITS-1:0]  pick;
   logic [SIZE_BITS-1:0] remainder;

   logic                 accept;
   logic [SIZE_BITS-1:0] in_size;
   logic                 in_range;
   logic [7:0]           bu_wide;
   logic [7:0]           lim_wide;
   logic [CNT_BITS-1:0]  scan_limit;
   logic                 last_step;

   assign accept     = start && !busy;
   assign in_size    = SIZE_BITS'(req_data.size_value);
   assign in_range   = {5'b0, req_data.block_index} < 8'(NUM_BLOCKS);
   assign bu_wide    = {4'b0, blocks_in_use_ff};
   assign lim_wide   = (bu_wide > 8'(NUM_BLOCKS)) ? 8'(NUM_BLOCKS) : bu_wide;
   assign scan_limit = CNT_BITS'(lim_wide);
   assign last_step  = (CNT_BITS'(cnt_ff) + CNT_BITS'(1)) == limit_ff;

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff    <= POL_FIRST;
         blocks_in_use_ff <= BLOCKS_IN_USE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIT_POLICY:    fit_policy_ff    <= csr_data[1:0];
            CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_data;
            default:           ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      req_size_in  = req_size_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      wr_en        = 1'b0;
      wr_addr      = IDX_BITS'(req_data.block_index);
      wr_data      = in_size;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_LOAD) begin
                  wr_en        = in_range;
                  rsp_valid_in = 1'b1;
                  rsp_in.granted        = 1'b0;
                  rsp_in.chosen_block   = req_data.block_index;
                  rsp_in.remaining_size = in_range ? 16'(in_size) : 16'd0;
               end else begin
                  ctl.clear   = 1'b1;
                  req_size_in = in_size;
                  limit_in    = scan_limit;
                  cnt_in      = '0;
                  state_in    = (scan_limit == '0) ? ST_UPDATE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.step = 1'b1;
            if (last_step) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + IDX_BITS'(1);
            end
         end
         ST_UPDATE: begin
            ctl.update   = 1'b1;
            rsp_valid_in = 1'b1;
            wr_addr      = pick;
            wr_data      = remainder;
            wr_en        = found;
            if (found) begin
               rsp_in.granted        = 1'b1;
               rsp_in.chosen_block   = 3'(pick);
               rsp_in.remaining_size = 16'(remainder);
            end else begin
               rsp_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      limit_ff    <= limit_in;
      req_size_ff <= req_size_in;
      rsp_ff      <= rsp_in;
   end

   fpba_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   fpba_scan_unit u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .policy    (fit_policy_ff),
      .req_size  (req_size_ff),
      .rd_data   (rd_data),
      .rd_index  (cnt_ff),
      .found     (found),
      .pick      (pick),
      .remainder (remainder)
   );

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !rsp_valid)
      else $error("result strobe during scan");

   a_alloc_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ACT_ALLOC |=> busy)
      else $error("allocate transfer did not start a scan");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ACT_LOAD |=> rsp_valid && !rsp_data.granted)
      else $error("load transfer gave no load result");

   a_grant_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted |-> $past(state_ff == ST_UPDATE))
      else $error("grant without an update step");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> CNT_BITS'(cnt_ff) < limit_ff)
      else $error("scan index beyond scan limit");

endmodule

`default_nettype wire

// ----- bench/fit_policy_block_allocator_tb.sv -----
// self-checking bench for the fit policy block allocator: directed table, then random phases
// depends on fpba_pkg and fit_policy_block_allocator; results checked by a predictor or typed rows
module fit_policy_block_allocator_tb;
   import fpba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] POL_UNUSED = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_3 = 2'd3;
   localparam int STALL_LIMIT  = 1000;
   localparam int SETTLE_TICKS = 12;
   localparam int NUM_PHASES   = 16;
   localparam int PHASE_MIXED  = 95;

   typedef struct {
      bit                        is_cfg;
      logic [CSR_IDX_BITS-1:0]   csr_idx;
      logic [CSR_DATA_BITS-1:0]  csr_val;
      req_type                   req;
      bit                        typed;
      rsp_type                   want;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // typed expectation travels with the request it belongs to
   bit                        typed_flag = 1'b0;
   rsp_type                   typed_rsp = '0;

   logic [SIZE_BITS-1:0]      model_free_size [NUM_BLOCKS];
   logic [1:0]                model_policy;
   logic [3:0]                model_scan_count;
   rsp_type                   alloc_rsp_queue [$];
   dir_row_type               directed_rows [$];
   int                        mismatch_count = 0;
   int                        stall_cycles = 0;
   bit                        no_idle = 1'b0;
   bit                        moved;
   rsp_type                   want;
   rsp_type                   predicted;

   fit_policy_block_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type compute_allocation(req_type r);
      rsp_type res;
      int      scan;
      int      pick;
      bit      found;
      logic [SIZE_BITS-1:0] v;
      res = '0;
      if (r.action == ACT_LOAD) begin
         model_free_size[r.block_index] = r.size_value;
         res.chosen_block   = r.block_index;
         res.remaining_size = r.size_value;
         return res;
      end
      scan  = (int'(model_scan_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(model_scan_count);
      found = 1'b0;
      pick  = 0;
      for (int j = 0; j < scan; j++) begin
         v = model_free_size[j];
         if (v >= r.size_value) begin
            if (!found) begin
               found = 1'b1;
               pick  = j;
               if (model_policy != POL_BEST && model_policy != POL_WORST)
                  break;
            end else if (model_policy == POL_BEST && v < model_free_size[pick]) begin
               pick = j;
            end else if (model_policy == POL_WORST && v > model_free_size[pick]) begin
               pick = j;
            end
         end
      end
      if (found) begin
         model_free_size[pick] = model_free_size[pick] - r.size_value;
         res.granted        = 1'b1;
         res.chosen_block   = IDX_BITS'(pick);
         res.remaining_size = model_free_size[pick];
      end
      return res;
   endfunction

   task automatic check_field(string field, logic [SIZE_BITS-1:0] exp_v,
                              logic [SIZE_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, field, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (model_free_size[k])
            model_free_size[k] = '0;
         model_policy     = POL_FIRST;
         model_scan_count = BLOCKS_IN_USE_RESET;
         alloc_rsp_queue.delete();
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved = 1'b1;
            if (alloc_rsp_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none actual %h", $realtime, rsp_data);
            end else begin
               want = alloc_rsp_queue.pop_front();
               check_field("granted", SIZE_BITS'(want.granted),
                           SIZE_BITS'(rsp_data.granted));
               check_field("chosen_block", SIZE_BITS'(want.chosen_block),
                           SIZE_BITS'(rsp_data.chosen_block));
               check_field("remaining_size", want.remaining_size, rsp_data.remaining_size);
            end
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == CSR_FIT_POLICY)
               model_policy = csr_data[1:0];
            else if (csr_index == CSR_BLOCKS_IN_USE)
               model_scan_count = csr_data;
         end
         if (start && !busy) begin
            moved = 1'b1;
            predicted = compute_allocation(req_data);
            alloc_rsp_queue.push_back(typed_flag ? typed_rsp : predicted);
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_item(req_type r, bit typed, rsp_type t);
      req_data   <= r;
      typed_flag <= typed;
      typed_rsp  <= t;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap();
      int n;
      int r;
      n = 0;
      r = $urandom_range(0, 99);
      if (!no_idle) begin
         if (r >= 90)
            n = $urandom_range(8, 40);
         else if (r >= 45)
            n = $urandom_range(1, 3);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (alloc_rsp_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic add_cfg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      dir_row_type row;
      row = '{is_cfg: 1'b1, csr_idx: idx, csr_val: val, req: '0, typed: 1'b0, want: '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_item(req_type r, bit typed, rsp_type t);
      dir_row_type row;
      row = '{is_cfg: 1'b0, csr_idx: '0, csr_val: '0, req: r, typed: typed, want: t};
      directed_rows.push_back(row);
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size(bit for_load);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      if (r <= (for_load ? 3 : 5))
         return SIZE_BITS'($urandom_range(0, 255));
      if (r <= 7)
         return SIZE_BITS'($urandom_range(0, 4095));
      return SIZE_BITS'($urandom);
   endfunction

   function automatic req_type random_item(bit force_load);
      req_type r;
      r.action      = (force_load || $urandom_range(0, 9) < 3) ? ACT_LOAD : ACT_ALLOC;
      r.block_index = IDX_BITS'($urandom_range(0, NUM_BLOCKS - 1));
      r.size_value  = pick_size(r.action == ACT_LOAD);
      return r;
   endfunction

   initial begin
      int r;
      // reset, extremes, every policy, scan count of zero, one and above the table
      add_item({ACT_ALLOC, 3'd7, 16'h0000}, 1'b1, {1'b1, 3'd0, 16'h0000});
      add_item({ACT_ALLOC, 3'd0, 16'hFFFF}, 1'b1, {1'b0, 3'd0, 16'h0000});
      add_item({ACT_LOAD, 3'd7, 16'hFFFF}, 1'b1, {1'b0, 3'd7, 16'hFFFF});
      add_item({ACT_LOAD, 3'd0, 16'h0000}, 1'b1, {1'b0, 3'd0, 16'h0000});
      add_item({ACT_LOAD, 3'd3, 16'd100}, 1'b1, {1'b0, 3'd3, 16'd100});
      add_item({ACT_LOAD, 3'd5, 16'd50}, 1'b1, {1'b0, 3'd5, 16'd50});
      add_item({ACT_LOAD, 3'd2, 16'h8000}, 1'b1, {1'b0, 3'd2, 16'h8000});
      add_item({ACT_LOAD, 3'd4, 16'd100}, 1'b1, {1'b0, 3'd4, 16'd100});
      add_item({ACT_ALLOC, 3'd5, 16'hFFFF}, 1'b1, {1'b1, 3'd7, 16'h0000});
      add_item({ACT_ALLOC, 3'd2, 16'd40}, 1'b0, '0);
      add_cfg(CSR_FIT_POLICY, CSR_DATA_BITS'(POL_BEST));
      add_item({ACT_ALLOC, 3'd1, 16'd40}, 1'b0, '0);
      add_item({ACT_ALLOC, 3'd6, 16'd60}, 1'b0, '0);
      add_cfg(CSR_FIT_POLICY, CSR_DATA_BITS'(POL_WORST));
      add_item({ACT_ALLOC, 3'd3, 16'd1}, 1'b0, '0);
      add_cfg(CSR_FIT_POLICY, CSR_DATA_BITS'(POL_UNUSED));
      add_item({ACT_ALLOC, 3'd4, 16'd0}, 1'b0, '0);
      add_cfg(CSR_BLOCKS_IN_USE, 4'd0);
      add_item({ACT_ALLOC, 3'd0, 16'd0}, 1'b1, {1'b0, 3'd0, 16'h0000});
      add_cfg(CSR_BLOCKS_IN_USE, 4'd15);
      add_item({ACT_ALLOC, 3'd7, 16'h7000}, 1'b0, '0);
      add_cfg(CSR_BLOCKS_IN_USE, 4'd1);
      add_item({ACT_ALLOC, 3'd0, 16'd1}, 1'b1, {1'b0, 3'd0, 16'h0000});
      add_cfg(CSR_SPARE_2, 4'hF);
      add_cfg(CSR_SPARE_3, 4'hF);
      add_item({ACT_ALLOC, 3'd0, 16'd0}, 1'b1, {1'b1, 3'd0, 16'h0000});
      add_cfg(CSR_BLOCKS_IN_USE, 4'd8);
      add_cfg(CSR_FIT_POLICY, CSR_DATA_BITS'(POL_FIRST));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_cfg) begin
            write_csr(directed_rows[k].csr_idx, directed_rows[k].csr_val);
         end else begin
            send_item(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
            idle_gap();
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_csr(CSR_FIT_POLICY, CSR_DATA_BITS'($urandom_range(0, 3)));
         r = $urandom_range(0, 9);
         if (r == 0)
            write_csr(CSR_BLOCKS_IN_USE, 4'd0);
         else if (r == 1)
            write_csr(CSR_BLOCKS_IN_USE, CSR_DATA_BITS'($urandom_range(9, 15)));
         else
            write_csr(CSR_BLOCKS_IN_USE, CSR_DATA_BITS'($urandom_range(1, NUM_BLOCKS)));
         no_idle = ($urandom_range(0, 3) == 0);
         // write random sizes into the table first so the scans see real free sizes
         for (int n = 0; n < NUM_BLOCKS; n++) begin
            send_item(random_item(1'b1), 1'b0, '0);
            idle_gap();
         end
         for (int n = 0; n < PHASE_MIXED; n++) begin
            if (n == PHASE_MIXED / 2 && phase % 2 == 0)
               drain();
            send_item(random_item(1'b0), 1'b0, '0);
            idle_gap();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
